// ===== rtl/tcr_pkg.sv =====
// tcr_pkg: shared types and constants of the tournament replacement engine
// no dependencies; imported by the engine and the checker
package tcr_pkg;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_RED1,
		S_RED2,
		S_READ,
		S_EXEC,
		S_SCAN
	} state_t;

	localparam logic [1:0] POL_LRU   = 2'd0;
	localparam logic [1:0] POL_RRIP  = 2'd1;
	localparam logic [1:0] POL_PCF   = 2'd2;
	localparam logic [1:0] POL_NONE  = 2'd3;

	localparam logic CMD_QUERY  = 1'b0;
	localparam logic CMD_UPDATE = 1'b1;

	localparam logic CFG_EPOCH_LIMIT = 1'b0;
	localparam logic CFG_HOT_THRESH  = 1'b1;

	localparam logic [1:0]  RRPV_MAX       = 2'd3;
	localparam logic [1:0]  RRPV_LONG      = 2'd2;
	localparam logic [2:0]  CTR_SAT        = 3'd7;
	localparam logic [2:0]  PC_CTR_INIT    = 3'd3;
	localparam logic [19:0] LIMIT_RESET    = 20'd10000;
	localparam logic [2:0]  THRESH_RESET   = 3'd4;
	localparam int          MASK_WAYS      = 16;

endpackage

// ===== rtl/tournament_cache_replacement_top.sv =====
// tournament_cache_replacement_top: set-dueling replacement engine (lru, srrip, pc-filtered srrip)
// depends on tcr_pkg and tcr_rem
//
// One transaction is handled at a time. A transaction enters when s_axis_tready is high,
// which it is only in the idle state; a result left waiting on the output does not hold
// off the next transaction until that one wants to deliver. The set index is reduced by
// SET_COUNT and the counter index of the pc by PC_TABLE_SIZE in remainder units, then the
// set by SAMPLE_SPACING: a single load each for a power-of-two size, otherwise four bits
// a cycle (the set and the pc run side by side, then the reduced set). After that the READ
// state reads the set's rrpv row, the pc counter and the first timestamp, and the EXEC state
// computes and writes back and offers the result; an lru query with every way valid instead
// walks the timestamps through the single 64-bit comparator in the SCAN state, one way a cycle.
// A stalled output adds its stall to the final step. After reset a clearing pass writes
// max(SET_COUNT*WAY_COUNT, PC_TABLE_SIZE) entries, one a cycle, before the first
// transaction is taken; configuration writes are taken throughout.
module tournament_cache_replacement_top #(
	parameter int SET_COUNT      = 2048,
	parameter int WAY_COUNT      = 16,
	parameter int PC_TABLE_SIZE  = 1024,
	parameter int SAMPLE_SPACING = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// set_index[10:0], way_index[14:11], way_valid_mask[30:15], program_counter[94:31],
	// was_hit[95]
	input  logic [95:0] s_axis_tdata,
	// cmd[0]
	input  logic [0:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// victim_way[3:0], set_policy[5:4], zero fill[7:6]
	output logic [7:0]  m_axis_tdata,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_addr,
	input  logic [19:0] cfg_data
);
	import tcr_pkg::*;

	localparam int SW     = $clog2(SET_COUNT);
	localparam int WW     = $clog2(WAY_COUNT);
	localparam int TOT    = SET_COUNT * WAY_COUNT;
	localparam int TW     = $clog2(TOT);
	localparam int PW     = $clog2(PC_TABLE_SIZE);
	localparam int QW     = $clog2(SAMPLE_SPACING);
	localparam int CLR_N  = (TOT > PC_TABLE_SIZE) ? TOT : PC_TABLE_SIZE;
	localparam int CLRW   = $clog2(CLR_N);

	// state and configuration
	state_t        state_q, state_d;
	logic [19:0]   limit_q;
	logic [2:0]    thresh_q;
	logic [CLRW-1:0] clr_q;

	// captured transaction
	logic          cmd_q;
	logic [3:0]    way_q;
	logic [15:0]   mask_q;
	logic          hit_q;

	// derived per transaction
	logic [1:0]    pol_q;
	logic          sample_q;
	logic [SW-1:0] set_q;
	logic [TW-1:0] base_q;
	logic [PW-1:0] pci_q;
	logic [WW-1:0] tidx_q, tidx_d;

	// lru scan
	logic [63:0]   best_t_q;
	logic [WW-1:0] best_w_q;

	// duelling counters
	logic [19:0]   miss_q [3];
	logic [19:0]   total_q;
	logic [1:0]    win_q;
	logic [63:0]   clock_q;

	// output register
	logic          out_valid_q;
	logic [3:0]    out_way_q;
	logic [1:0]    out_pol_q;

	// memories
	logic [WAY_COUNT-1:0][1:0] rrpv_mem [SET_COUNT];
	logic [63:0]               touch_mem [TOT];
	logic [2:0]                pc_mem [PC_TABLE_SIZE];
	logic [WAY_COUNT-1:0][1:0] rrpv_rd_q;
	logic [63:0]               touch_rd_q;
	logic [2:0]                pc_rd_q;

	logic                      r_we, t_we, p_we;
	logic [SW-1:0]             r_wa;
	logic [TW-1:0]             t_wa;
	logic [PW-1:0]             p_wa;
	logic [WAY_COUNT-1:0][1:0] r_wd;
	logic [63:0]               t_wd;
	logic [2:0]                p_wd;

	// remainder units
	logic          s_hs, out_free;
	logic          rs_start, rq_start;
	logic          rs_busy, rp_busy, rq_busy;
	logic [SW-1:0] rs_rem;
	logic [PW-1:0] rp_rem;
	logic [QW-1:0] rq_rem;

	assign s_hs     = s_axis_tvalid && s_axis_tready;
	assign out_free = !out_valid_q || m_axis_tready;
	assign rs_start = s_hs;

	tcr_rem #(.VW(11), .DIV(SET_COUNT)) u_rem_set (
		.clk(clk), .arst_n(arst_n), .start(rs_start), .value(s_axis_tdata[10:0]),
		.busy(rs_busy), .rem(rs_rem)
	);

	tcr_rem #(.VW(60), .DIV(PC_TABLE_SIZE)) u_rem_pc (
		.clk(clk), .arst_n(arst_n), .start(rs_start), .value(s_axis_tdata[94:35]),
		.busy(rp_busy), .rem(rp_rem)
	);

	tcr_rem #(.VW(SW), .DIV(SAMPLE_SPACING)) u_rem_spc (
		.clk(clk), .arst_n(arst_n), .start(rq_start), .value(rs_rem),
		.busy(rq_busy), .rem(rq_rem)
	);

	// way classification
	logic [WAY_COUNT-1:0] way_vld;
	logic [WAY_COUNT-1:0] way_hot;
	logic                 any_inv, any_hot;
	logic [WW-1:0]        first_inv, first_hot, first_aged;
	logic [1:0]           rmax, rstep;
	logic [WAY_COUNT-1:0][1:0] aged;
	logic                 way_ok;
	logic [WW-1:0]        way_ix;

	assign way_ok = ({2'b00, way_q} < 6'(WAY_COUNT));
	assign way_ix = WW'(way_q);

	always_comb begin
		for (int w = 0; w < WAY_COUNT; w++) begin
			way_vld[w] = (w >= MASK_WAYS) ? 1'b1 : mask_q[w % MASK_WAYS];
			way_hot[w] = !way_vld[w] || (rrpv_rd_q[w] == RRPV_MAX);
		end
		any_inv   = !(&way_vld);
		any_hot   = |way_hot;
		first_inv = '0;
		first_hot = '0;
		for (int w = WAY_COUNT - 1; w >= 0; w--) begin
			if (!way_vld[w]) first_inv = WW'(w);
			if (way_hot[w]) first_hot = WW'(w);
		end
		rmax = '0;
		for (int w = 0; w < WAY_COUNT; w++) begin
			if (rrpv_rd_q[w] > rmax) rmax = rrpv_rd_q[w];
		end
		rstep      = RRPV_MAX - rmax;
		first_aged = '0;
		for (int w = 0; w < WAY_COUNT; w++) begin
			aged[w] = rrpv_rd_q[w] + rstep;
		end
		for (int w = WAY_COUNT - 1; w >= 0; w--) begin
			if (aged[w] == RRPV_MAX) first_aged = WW'(w);
		end
	end

	// epoch arithmetic for a miss
	logic [19:0] miss_n [3];
	logic [19:0] total_n;
	logic [1:0]  best_pol;
	logic [63:0] clock_n;
	logic [1:0]  ins_rrpv;
	logic [2:0]  ctr_n;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			miss_n[i] = miss_q[i];
		end
		total_n = total_q;
		if (sample_q) begin
			miss_n[pol_q] = miss_q[pol_q] + 20'd1;
			total_n       = total_q + 20'd1;
		end
		best_pol = POL_LRU;
		if (miss_n[1] < miss_n[0]) best_pol = POL_RRIP;
		if (miss_n[2] < miss_n[best_pol]) best_pol = POL_PCF;
		clock_n = clock_q + 64'd1;

		ctr_n    = pc_rd_q;
		ins_rrpv = '0;
		if (hit_q) begin
			if (pc_rd_q != CTR_SAT) ctr_n = pc_rd_q + 3'd1;
		end else begin
			if (pc_rd_q != 3'd0) ctr_n = pc_rd_q - 3'd1;
			case (pol_q)
				POL_RRIP:  ins_rrpv = RRPV_LONG;
				POL_PCF:   ins_rrpv = (pc_rd_q >= thresh_q) ? 2'd0 : RRPV_LONG;
				default:   ins_rrpv = 2'd0;
			endcase
		end
	end

	// next state and memory writes
	logic exec_go;
	logic scan_last;
	logic take_less;

	assign exec_go   = (state_q == S_EXEC) && out_free;
	assign scan_last = (tidx_q == WW'(WAY_COUNT - 1));
	assign take_less = (touch_rd_q < best_t_q);

	always_comb begin
		state_d  = state_q;
		rq_start = 1'b0;
		tidx_d   = tidx_q;
		r_we = 1'b0; r_wa = set_q; r_wd = rrpv_rd_q;
		t_we = 1'b0; t_wa = base_q + TW'(way_ix); t_wd = clock_n;
		p_we = 1'b0; p_wa = pci_q; p_wd = ctr_n;
		unique case (state_q)
			S_CLEAR: begin
				// one entry of each store per cycle
				t_we = ({1'b0, clr_q} < (CLRW + 1)'(TOT));
				t_wa = clr_q[TW-1:0];
				t_wd = '0;
				r_we = ({1'b0, clr_q} < (CLRW + 1)'(SET_COUNT));
				r_wa = clr_q[SW-1:0];
				r_wd = {WAY_COUNT{RRPV_MAX}};
				p_we = ({1'b0, clr_q} < (CLRW + 1)'(PC_TABLE_SIZE));
				p_wa = clr_q[PW-1:0];
				p_wd = PC_CTR_INIT;
				if (clr_q == CLRW'(CLR_N - 1)) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (s_hs) state_d = S_RED1;
			end
			S_RED1: begin
				if (!rs_busy && !rp_busy) begin
					rq_start = 1'b1;
					state_d  = S_RED2;
				end
			end
			S_RED2: begin
				tidx_d = '0;
				if (!rq_busy) state_d = S_READ;
			end
			S_READ: begin
				state_d = S_EXEC;
			end
			S_EXEC: begin
				if (cmd_q == CMD_QUERY && pol_q == POL_LRU && !any_inv) begin
					// every way valid: walk the timestamps
					tidx_d  = WW'(1);
					state_d = S_SCAN;
				end else if (out_free) begin
					state_d = S_IDLE;
					if (cmd_q == CMD_QUERY) begin
						if (pol_q != POL_LRU && !any_hot) begin
							r_we = 1'b1;
							r_wd = aged;
						end
					end else begin
						r_wd[way_ix] = hit_q ? 2'd0 : ins_rrpv;
						r_we = way_ok;
						t_we = way_ok;
						p_we = (pol_q == POL_PCF);
					end
				end
			end
			S_SCAN: begin
				if (scan_last) begin
					if (out_free) state_d = S_IDLE;
				end else begin
					tidx_d = tidx_q + WW'(1);
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			clr_q    <= '0;
			limit_q  <= LIMIT_RESET;
			thresh_q <= THRESH_RESET;
			win_q    <= POL_RRIP;
			total_q  <= '0;
			clock_q  <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				miss_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) clr_q <= clr_q + CLRW'(1);
			if (cfg_we) begin
				unique case (cfg_addr[0])
					CFG_EPOCH_LIMIT: limit_q  <= cfg_data;
					CFG_HOT_THRESH:  thresh_q <= cfg_data[2:0];
					default: ;
				endcase
			end
			if (out_valid_q && m_axis_tready) out_valid_q <= 1'b0;
			if (exec_go && !(cmd_q == CMD_QUERY && pol_q == POL_LRU && !any_inv)) begin
				out_valid_q <= 1'b1;
				if (cmd_q == CMD_UPDATE) begin
					clock_q <= clock_n;
					if (!hit_q) begin
						if (total_n >= limit_q) begin
							// epoch ends: fewest misses wins, first on a tie
							win_q   <= best_pol;
							total_q <= '0;
							for (int i = 0; i < 3; i++) begin
								miss_q[i] <= '0;
							end
						end else begin
							total_q <= total_n;
							for (int i = 0; i < 3; i++) begin
								miss_q[i] <= miss_n[i];
							end
						end
					end
				end
			end
			if (state_q == S_SCAN && scan_last && out_free) out_valid_q <= 1'b1;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		tidx_q <= tidx_d;
		if (s_hs) begin
			cmd_q    <= s_axis_tuser[0];
			way_q    <= s_axis_tdata[14:11];
			mask_q   <= s_axis_tdata[30:15];
			hit_q    <= s_axis_tdata[95];
		end
		if (state_q == S_RED1 && !rs_busy && !rp_busy) begin
			set_q  <= rs_rem;
			base_q <= TW'(rs_rem * WAY_COUNT);
			pci_q  <= rp_rem;
		end
		if (state_q == S_RED2 && !rq_busy) begin
			sample_q <= (rq_rem < QW'(3));
			pol_q    <= (rq_rem < QW'(3)) ? rq_rem[1:0] : win_q;
		end
		if (state_q == S_EXEC) begin
			best_t_q <= touch_rd_q;
			best_w_q <= '0;
		end
		if (state_q == S_SCAN && take_less) begin
			best_t_q <= touch_rd_q;
			best_w_q <= tidx_q;
		end
		if (exec_go) begin
			out_pol_q <= pol_q;
			if (cmd_q == CMD_UPDATE) begin
				out_way_q <= '0;
			end else if (pol_q == POL_LRU) begin
				out_way_q <= 4'(first_inv);
			end else if (any_hot) begin
				out_way_q <= 4'(first_hot);
			end else begin
				out_way_q <= 4'(first_aged);
			end
		end
		if (state_q == S_SCAN && scan_last && out_free) begin
			out_pol_q <= pol_q;
			out_way_q <= take_less ? 4'(tidx_q) : 4'(best_w_q);
		end
	end

	// stores: one write and one registered read each
	always_ff @(posedge clk) begin
		if (r_we) rrpv_mem[r_wa] <= r_wd;
		rrpv_rd_q <= rrpv_mem[set_q];
	end

	always_ff @(posedge clk) begin
		if (t_we) touch_mem[t_wa] <= t_wd;
		touch_rd_q <= touch_mem[base_q + TW'(tidx_d)];
	end

	always_ff @(posedge clk) begin
		if (p_we) pc_mem[p_wa] <= p_wd;
		pc_rd_q <= pc_mem[pci_q];
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, out_pol_q, out_way_q};

endmodule

// ===== rtl/tcr_rem.sv =====
// tcr_rem: remainder of an unsigned value by a fixed divisor
// four bits per cycle by a reciprocal digit estimate for a general divisor,
// a single load for a power of two; depends on nothing outside this file
module tcr_rem #(
	parameter int VW  = 11,
	parameter int DIV = 32
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     start,
	input  logic [VW-1:0]                            value,
	output logic                                     busy,
	output logic [((DIV > 1) ? $clog2(DIV) : 1)-1:0] rem
);
	localparam int RW   = (DIV > 1) ? $clog2(DIV) : 1;
	localparam bit POW2 = ((DIV & (DIV - 1)) == 0);
	localparam int EW   = (VW > RW) ? VW : RW;

	logic [RW-1:0] rem_q;
	assign rem = rem_q;

	generate
		if (POW2) begin : g_mask
			logic [EW-1:0] ext;
			logic          busy_q;
			assign ext  = EW'(value);
			assign busy = busy_q;
			// power of two: the remainder is the low bits
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					busy_q <= 1'b0;
				end else begin
					busy_q <= 1'b0;
				end
			end
			always_ff @(posedge clk) begin
				if (start) begin
					rem_q <= ext[RW-1:0];
				end
			end
		end else begin : g_digit
			localparam int     K     = 4;
			localparam int     NCH   = (VW + K - 1) / K;
			localparam int     SHW   = NCH * K;
			localparam int     VDW   = RW + K;
			localparam int     MW    = K + 1;
			localparam int     NW    = $clog2(NCH + 1);
			localparam longint RECIP = (longint'(1) << VDW) / longint'(DIV);
			logic [SHW-1:0]    sh_q;
			logic [NW-1:0]     cnt_q;
			logic              busy_q;
			logic [VDW-1:0]    part;
			logic [VDW+MW-1:0] prod;
			logic [K-1:0]      qest;
			logic [VDW-1:0]    r1;
			logic [VDW-1:0]    r2;
			assign busy = busy_q;
			// partial remainder with the next digit, quotient digit from the reciprocal
			// (never above the true digit and at most one below it)
			assign part = {rem_q, sh_q[SHW-1 -: K]};
			assign prod = {{MW{1'b0}}, part} * (VDW + MW)'(RECIP);
			assign qest = prod[VDW +: K];
			assign r1   = part - (VDW'(qest) * VDW'(DIV));
			assign r2   = (r1 >= VDW'(DIV)) ? (r1 - VDW'(DIV)) : r1;
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					busy_q <= 1'b0;
					cnt_q  <= '0;
				end else if (start) begin
					busy_q <= 1'b1;
					cnt_q  <= NW'(NCH);
				end else if (busy_q) begin
					cnt_q <= cnt_q - NW'(1);
					if (cnt_q == NW'(1)) begin
						busy_q <= 1'b0;
					end
				end
			end
			always_ff @(posedge clk) begin
				if (start) begin
					sh_q  <= SHW'(value);
					rem_q <= '0;
				end else if (busy_q) begin
					sh_q  <= sh_q << K;
					rem_q <= r2[RW-1:0];
				end
			end
		end
	endgenerate

endmodule

// ===== rtl/tcr_checker.sv =====
// tcr_checker: port-level checks of the replacement engine over time
// depends on tcr_pkg; bound to tournament_cache_replacement_top
module tcr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [95:0] s_axis_tdata,
	input logic [0:0]  s_axis_tuser,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [7:0]  m_axis_tdata,
	input logic        cfg_we,
	input logic [0:0]  cfg_addr,
	input logic [19:0] cfg_data
);
	import tcr_pkg::*;

	logic       s_hs, m_hs;
	logic [1:0] pend_q;

	assign s_hs = s_axis_tvalid && s_axis_tready;
	assign m_hs = m_axis_tvalid && m_axis_tready;

	// transactions accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + {1'b0, s_hs} - {1'b0, m_hs};
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped while stalled");

	a_policy: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[5:4] != POL_NONE)
		else $error("policy code out of range");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_hs |=> !s_hs)
		else $error("two transactions accepted back to back");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> pend_q != 2'd0)
		else $error("result without an accepted transaction");

	logic unused_ports;
	assign unused_ports = ^{s_axis_tdata, s_axis_tuser, cfg_we, cfg_addr, cfg_data};

endmodule

bind tournament_cache_replacement_top tcr_checker u_tcr_checker (.*);
